FILE: hw/rtl/lfk_pkg.sv
// Shared constants for the leg forward kinematics pipeline.
`default_nettype none
package lfk_pkg;
   localparam int unsigned OUT_BITS = 19;
   localparam int unsigned SIN_A = 51472;
   localparam int unsigned SIN_B = 21024;
   localparam int unsigned SIN_C = 2320;
   localparam logic [1:0] CSR_HIP_OFFSET = 2'd0;
   localparam logic [1:0] CSR_UPPER_LINK = 2'd1;
   localparam logic [1:0] CSR_LOWER_LINK = 2'd2;
endpackage
`default_nettype wire

FILE: hw/rtl/leg_forward_kinematics_top.sv
// Top level: angle pipeline, six sine cells, product and rounding stages.
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | three angles
//  rsp     | out | rsp_valid/ready    | x, left y/z, right y/z
//  csr     | in  | csr_write_enable   | index, data
// One word per cycle unless the output stalls; words pass the sine cells, then
// the multiply/round stages. Reset clears valid bits and length registers.
// Whole pipeline advances when the output stage is empty or being taken.
`default_nettype none
module leg_forward_kinematics_top #(
   parameter int ANGLE_BITS  = 16,
   parameter int LENGTH_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic signed [15:0] req_abduction_angle,
   input  wire logic signed [15:0] req_hip_angle,
   input  wire logic signed [15:0] req_knee_angle,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [18:0] rsp_foot_x,
   output      logic signed [18:0] rsp_left_foot_y,
   output      logic signed [18:0] rsp_left_foot_z,
   output      logic signed [18:0] rsp_right_foot_y,
   output      logic signed [18:0] rsp_right_foot_z,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);
   localparam int DEPTH = 10;
   localparam int LW = LENGTH_BITS + 1;
   localparam int PW = LW + 17;          // length times sine, Q15
   localparam int SW = PW + 1;           // x / lyz, Q15
   localparam int QW = SW + 17;          // Q30 products
   localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

   logic [LENGTH_BITS-1:0] h_ff, hu_ff, hl_ff;
   logic [DEPTH-1:0] vld_ff;
   logic adv;

   assign adv = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         h_ff <= '0; hu_ff <= '0; hl_ff <= '0;
      end else begin
         if (adv) vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
         if (csr_write_enable) begin
            unique case (csr_index)
               lfk_pkg::CSR_HIP_OFFSET: h_ff  <= LENGTH_BITS'(csr_data);
               lfk_pkg::CSR_UPPER_LINK: hu_ff <= LENGTH_BITS'(csr_data);
               lfk_pkg::CSR_LOWER_LINK: hl_ff <= LENGTH_BITS'(csr_data);
               default: ;
            endcase
         end
      end
   end

   // phases: low ANGLE_BITS of each angle, scaled so 2^32 is a full turn
   logic [31:0] pg, pa, pab, pg_c, pa_c, pab_c;
   always_comb begin
      pg  = ({16'h0, req_abduction_angle} & ANGLE_MASK) << (32 - ANGLE_BITS);
      pa  = ({16'h0, req_hip_angle} & ANGLE_MASK) << (32 - ANGLE_BITS);
      pab = pa + (({16'h0, req_knee_angle} & ANGLE_MASK) << (32 - ANGLE_BITS));
      pg_c = pg + 32'h4000_0000;
      pa_c = pa + 32'h4000_0000;
      pab_c = pab + 32'h4000_0000;
   end

   logic signed [16:0] sg, cg, sa, ca, sab, cab;
   lfk_sin_cell u_sg  (.clock, .en(adv), .phase(pg),    .sine(sg));
   lfk_sin_cell u_cg  (.clock, .en(adv), .phase(pg_c),  .sine(cg));
   lfk_sin_cell u_sa  (.clock, .en(adv), .phase(pa),    .sine(sa));
   lfk_sin_cell u_ca  (.clock, .en(adv), .phase(pa_c),  .sine(ca));
   lfk_sin_cell u_sab (.clock, .en(adv), .phase(pab),   .sine(sab));
   lfk_sin_cell u_cab (.clock, .en(adv), .phase(pab_c), .sine(cab));

   logic signed [LW-1:0] h_s, hu_s, hl_s;
   assign h_s = $signed({1'b0, h_ff});
   assign hu_s = $signed({1'b0, hu_ff});
   assign hl_s = $signed({1'b0, hl_ff});

   // stage 6: link and hip offset products
   logic signed [PW-1:0] p_usa_ff, p_lsab_ff, p_uca_ff, p_lcab_ff, p_hc_ff, p_hs_ff;
   logic signed [16:0] sg6_ff, cg6_ff;
   // stage 7: sums
   logic signed [SW-1:0] x7_ff, l7_ff;
   logic signed [PW-1:0] hc7_ff, hs7_ff;
   logic signed [16:0] sg7_ff, cg7_ff;
   // stage 8: Q30 products
   logic signed [QW-1:0] ls8_ff, lc8_ff, hc8_ff, hs8_ff;
   logic signed [SW-1:0] x8_ff;
   // stage 9: combine
   logic signed [QW+1:0] ly9_ff, lz9_ff, ry9_ff, rz9_ff;
   logic signed [SW-1:0] x9_ff;
   // stage 10: rounded output
   logic signed [18:0] ox_ff, oly_ff, olz_ff, ory_ff, orz_ff;

   function automatic logic signed [18:0] rnd30(input logic signed [QW+1:0] v);
      logic signed [QW+1:0] w;
      w = v + (QW+2)'(1 << 29);
      return 19'(w >>> 30);
   endfunction

   logic signed [SW-1:0] xr;
   assign xr = (x9_ff + SW'(1 << 14)) >>> 15;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_usa_ff  <= PW'(hu_s * sa);
         p_lsab_ff <= PW'(hl_s * sab);
         p_uca_ff  <= PW'(hu_s * ca);
         p_lcab_ff <= PW'(hl_s * cab);
         p_hc_ff   <= PW'(h_s * cg);
         p_hs_ff   <= PW'(h_s * sg);
         sg6_ff <= sg; cg6_ff <= cg;
         x7_ff <= SW'(p_usa_ff) - SW'(p_lsab_ff);
         l7_ff <= SW'(p_uca_ff) + SW'(p_lcab_ff);
         hc7_ff <= p_hc_ff; hs7_ff <= p_hs_ff;
         sg7_ff <= sg6_ff; cg7_ff <= cg6_ff;
         ls8_ff <= QW'(l7_ff * sg7_ff);
         lc8_ff <= QW'(l7_ff * cg7_ff);
         hc8_ff <= QW'(hc7_ff) <<< 15;
         hs8_ff <= QW'(hs7_ff) <<< 15;
         x8_ff <= x7_ff;
         ly9_ff <= -((QW+2)'(hc8_ff) + (QW+2)'(ls8_ff));
         lz9_ff <= (QW+2)'(hs8_ff) - (QW+2)'(lc8_ff);
         ry9_ff <= (QW+2)'(hc8_ff) - (QW+2)'(ls8_ff);
         rz9_ff <= -(QW+2)'(hs8_ff) - (QW+2)'(lc8_ff);
         x9_ff <= x8_ff;
         ox_ff  <= 19'(xr);
         oly_ff <= rnd30(ly9_ff);
         olz_ff <= rnd30(lz9_ff);
         ory_ff <= rnd30(ry9_ff);
         orz_ff <= rnd30(rz9_ff);
      end
   end

   assign rsp_foot_x = ox_ff;
   assign rsp_left_foot_y = oly_ff;
   assign rsp_left_foot_z = olz_ff;
   assign rsp_right_foot_y = ory_ff;
   assign rsp_right_foot_z = orz_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_foot_x))
      else $error("output changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("not ready with empty output");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted word lost");
endmodule
`default_nettype wire

FILE: hw/rtl/lfk_sin_cell.sv
// Pipelined Q1.15 sine of a 32-bit phase: fold, square, inner term, outer term, product and sign.
`default_nettype none
module lfk_sin_cell (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [31:0]        phase,
   output      logic signed [16:0] sine
);
   localparam logic [16:0] SIN_C_W = 17'(lfk_pkg::SIN_C);

   // stage 1: fold into first quadrant
   logic [16:0] u1_ff, u1_in;
   logic        n1_ff;
   logic [30:0] half;
   // stage 2: u2
   logic [16:0] u2_ff, uu2_ff;
   logic        n2_ff;
   // stage 3: inner term
   logic [16:0] t3_ff, u3_ff, uu3_ff;
   logic        n3_ff;
   // stage 4: outer term
   logic [16:0] t4_ff, u4_ff;
   logic        n4_ff;
   // stage 5: product and sign
   logic signed [16:0] s5_ff;
   logic [33:0] p2, p3, p4, p5;
   logic [31:0] r5;
   logic [15:0] rs;

   always_comb begin
      half = phase[30:0];
      if ({1'b0, half} > 32'h4000_0000) begin
         half = 31'h4000_0000 - (half - 31'h4000_0000);
      end
      u1_in = 17'(half >> 15);
      p2 = 34'(u1_ff) * 34'(u1_ff);
      p3 = 34'(SIN_C_W) * 34'(uu2_ff);
      p4 = 34'(t3_ff) * 34'(uu3_ff);
      p5 = 34'(u4_ff) * 34'(t4_ff);
      r5 = 32'(p5 >> 15);
      rs = (r5 > 32'd32767) ? 16'd32767 : r5[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u1_ff  <= u1_in;
         n1_ff  <= phase[31];
         u2_ff  <= u1_ff;
         uu2_ff <= 17'(p2 >> 15);
         n2_ff  <= n1_ff;
         t3_ff  <= 17'(lfk_pkg::SIN_B) - 17'(p3 >> 15);
         u3_ff  <= u2_ff;
         uu3_ff <= uu2_ff;
         n3_ff  <= n2_ff;
         t4_ff  <= 17'(lfk_pkg::SIN_A) - 17'(p4 >> 15);
         u4_ff  <= u3_ff;
         n4_ff  <= n3_ff;
         s5_ff  <= n4_ff ? -$signed({1'b0, rs}) : $signed({1'b0, rs});
      end
   end
   assign sine = s5_ff;
endmodule
`default_nettype wire
